[design/qvdd_pkg.sv]
// qvdd_pkg: transaction types, register indexes and constants for the
// qos_vote_deferred_decrease voter. No dependencies; imported by the top level.
package qvdd_pkg;

    // field widths
    localparam int BW_W   = 20;
    localparam int CLK_W  = 32;
    localparam int TOT_W  = 22;
    localparam int KHZ_W  = 23;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // bandwidth slots within one pipeline row
    localparam int BW_RD_AVG = 0;
    localparam int BW_RD_PK  = 1;
    localparam int BW_WR_AVG = 2;
    localparam int BW_WR_PK  = 3;
    localparam int BW_SLOTS  = 4;

    // saturation limit for the totals
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // hz to khz: floor(x / 1000) == (x * KHZ_RECIP) >> KHZ_SHIFT for all 32-bit x
    localparam int               RECIP_W   = 29;
    localparam int               KHZ_SHIFT = 38;
    localparam logic [RECIP_W-1:0] KHZ_RECIP = 29'd274877907;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_MIN_RD_AVG = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MIN_RD_PK  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MIN_WR_AVG = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MIN_WR_PK  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MIN_CLK    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_BW_EN      = 3'd5;
    localparam logic [CFG_AW-1:0] REG_CLK_EN     = 3'd6;

    // request types
    localparam logic REQ_COMMIT  = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [1:0]       pipe_index;
        logic [BW_W-1:0]  read_average_request;
        logic [BW_W-1:0]  read_peak_request;
        logic [BW_W-1:0]  write_average_request;
        logic [BW_W-1:0]  write_peak_request;
        logic [CLK_W-1:0] clock_request_hz;
    } vote_req_t;

    typedef struct packed {
        logic             read_vote_valid;
        logic [TOT_W-1:0] read_average_total;
        logic [TOT_W-1:0] read_peak_total;
        logic             write_vote_valid;
        logic [TOT_W-1:0] write_average_total;
        logic [TOT_W-1:0] write_peak_total;
        logic             bandwidth_commit;
        logic             clock_vote_valid;
        logic [KHZ_W-1:0] clock_vote_khz;
    } vote_rsp_t;

    // one pipeline's stored state
    typedef struct packed {
        logic [BW_SLOTS-1:0][BW_W-1:0] cur_bw;
        logic [BW_SLOTS-1:0][BW_W-1:0] pend_bw;
        logic [CLK_W-1:0]              cur_clk;
        logic [CLK_W-1:0]              pend_clk;
    } pipe_row_t;

    typedef struct packed {
        logic [CLK_W-1:0] val;
        logic [CLK_W-1:0] pend;
        logic             upd;
    } choose_t;

    // deferred-decrease selection: raises apply now, a decrease waits one commit
    function automatic choose_t choose_f(logic [CLK_W-1:0] val, logic [CLK_W-1:0] pend,
                                         logic [CLK_W-1:0] cur);
        choose_t r;
        r.val  = val;
        r.pend = '0;
        r.upd  = 1'b0;
        if (val == cur) begin
            r.upd = 1'b0;
        end
        else if (val > cur) begin
            r.upd = 1'b1;
        end
        else if (pend != '0) begin
            r.upd = 1'b1;
            if (val < pend) begin
                r.val  = pend;
                r.pend = val;
            end
        end
        else begin
            r.pend = val;
        end
        return r;
    endfunction

endpackage

[design/qos_vote_deferred_decrease.sv]
// qos_vote_deferred_decrease: per-pipeline bandwidth and core clock voter.
// Depends on qvdd_pkg for the transaction structs, register indexes and constants.
//
// Usage:
//  - request channel: cmd is taken at a rising edge with start high and busy low.
//  - result channel: one result per request, shown on result for exactly one
//    cycle with done high; the receiver cannot hold it off.
//  - configuration: cfg_write high writes cfg_data into register cfg_index at
//    the edge; write only while the block is idle.
//  - sequencing: busy is high through the calc and div states after acceptance
//    and falls as done rises, so a new request is not taken while one is in
//    flight, but can be taken in the cycle where the previous result is shown.
//  - the result passes through the per-pipeline state memory (a registered read
//    at acceptance, then a read-modify-write in the calc state) and the
//    registered reciprocal multiply that turns the chosen clock into kHz.
//  - running sums of all pipelines' current bandwidth votes live in registers,
//    so a vote's totals come from one subtract and add, not a walk over rows.
//  - reset clears the configuration, the row valid bits and the running sums;
//    a row that was never written since reset reads as all zero.
module qos_vote_deferred_decrease #(
    parameter int NUM_PIPES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  qvdd_pkg::vote_req_t                 cmd,
    output logic                                done,
    output qvdd_pkg::vote_rsp_t                 result,
    input  logic                                cfg_write,
    input  logic [qvdd_pkg::CFG_AW-1:0]         cfg_index,
    input  logic [qvdd_pkg::CFG_DW-1:0]         cfg_data
);
    import qvdd_pkg::*;

    localparam int PW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int SW = BW_W + ((NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 0);
    localparam int TW = (SW + 1 > TOT_W + 1) ? SW + 1 : TOT_W + 1;
    localparam int PRODW = CLK_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [BW_SLOTS-1:0][BW_W-1:0] min_bw_reg;
    logic [CLK_W-1:0]              min_clk_reg;
    logic                          bw_en_reg;
    logic                          clk_en_reg;

    // request and memory
    vote_req_t              req_reg;
    logic [PW-1:0]          addr_reg;
    pipe_row_t              row_mem [NUM_PIPES];
    pipe_row_t              row_rd_reg;
    logic [NUM_PIPES-1:0]   row_valid_reg;
    logic [BW_SLOTS-1:0][SW-1:0] sum_reg;

    // result path
    vote_rsp_t              rsp_reg;
    logic                   clk_vote_reg;
    logic [CLK_W-1:0]       clk_val_reg;
    logic                   done_reg;

    logic                   accept;
    logic [PW-1:0]          cmd_addr;
    logic [3:0]             cmd_pipe_wide;

    assign accept        = start && (state_reg == ST_IDLE);
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign result        = rsp_reg;
    assign cmd_pipe_wide = {2'b00, cmd.pipe_index};
    assign cmd_addr      = cmd_pipe_wide[PW-1:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bw_reg  <= '0;
            min_clk_reg <= '0;
            bw_en_reg   <= 1'b0;
            clk_en_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_RD_AVG: min_bw_reg[BW_RD_AVG] <= cfg_data[BW_W-1:0];
                REG_MIN_RD_PK:  min_bw_reg[BW_RD_PK]  <= cfg_data[BW_W-1:0];
                REG_MIN_WR_AVG: min_bw_reg[BW_WR_AVG] <= cfg_data[BW_W-1:0];
                REG_MIN_WR_PK:  min_bw_reg[BW_WR_PK]  <= cfg_data[BW_W-1:0];
                REG_MIN_CLK:    min_clk_reg           <= cfg_data[CLK_W-1:0];
                REG_BW_EN:      bw_en_reg             <= cfg_data[0];
                REG_CLK_EN:     clk_en_reg            <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_CALC;
            ST_CALC: state_next = ST_DIV;
            ST_DIV:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture the request transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= cmd;
            addr_reg <= cmd_addr;
        end
    end

    // read-modify-write datapath
    logic                          in_range;
    logic                          release_req;
    logic                          row_ok;
    pipe_row_t                     row_eff;
    pipe_row_t                     row_base;
    pipe_row_t                     row_new;
    logic [BW_SLOTS-1:0][BW_W-1:0] bw_req;
    choose_t [BW_SLOTS-1:0]        bw_ch;
    logic [BW_SLOTS-1:0][BW_W-1:0] bw_val;
    logic [1:0]                    pair_upd;
    logic [1:0]                    pair_raise;
    logic [BW_SLOTS-1:0][SW-1:0]   others;
    logic [BW_SLOTS-1:0][TW-1:0]   tot_wide;
    logic [BW_SLOTS-1:0][TOT_W-1:0] tot_sat;
    logic [BW_SLOTS-1:0][SW-1:0]   sum_next;
    logic [CLK_W-1:0]              clk_req;
    choose_t                       clk_ch;
    logic [CLK_W-1:0]              clk_val;
    logic                          clk_upd;
    vote_rsp_t                     rsp_next;

    always_comb
    begin
        in_range    = (5'(req_reg.pipe_index) < 5'(NUM_PIPES));
        release_req = (req_reg.req_type == REQ_RELEASE);
        row_ok      = in_range && row_valid_reg[addr_reg];
        row_eff     = row_ok ? row_rd_reg : '0;
        row_base    = release_req ? '0 : row_eff;

        bw_req[BW_RD_AVG] = req_reg.read_average_request;
        bw_req[BW_RD_PK]  = req_reg.read_peak_request;
        bw_req[BW_WR_AVG] = req_reg.write_average_request;
        bw_req[BW_WR_PK]  = req_reg.write_peak_request;
        if (release_req)
        begin
            bw_req = '0;
        end

        // deferred-decrease choice for each bandwidth slot
        for (int j = 0; j < BW_SLOTS; j++)
        begin
            bw_ch[j]  = choose_f(CLK_W'(bw_req[j]), CLK_W'(row_base.pend_bw[j]),
                                 CLK_W'(row_base.cur_bw[j]));
            bw_val[j] = bw_ch[j].val[BW_W-1:0];
        end

        // floors for a non-zero average/peak pair
        for (int d = 0; d < 2; d++)
        begin
            pair_raise[d] = 1'b0;
            if ((bw_val[2*d] != '0) || (bw_val[2*d+1] != '0))
            begin
                if (bw_val[2*d] < min_bw_reg[2*d])
                begin
                    bw_val[2*d]   = min_bw_reg[2*d];
                    pair_raise[d] = 1'b1;
                end
                if (bw_val[2*d+1] < min_bw_reg[2*d+1])
                begin
                    bw_val[2*d+1] = min_bw_reg[2*d+1];
                    pair_raise[d] = 1'b1;
                end
            end
            pair_upd[d] = bw_en_reg && (release_req || bw_ch[2*d].upd ||
                                        bw_ch[2*d+1].upd || pair_raise[d]);
        end

        // totals against the other pipelines and new stored values
        for (int j = 0; j < BW_SLOTS; j++)
        begin
            others[j]   = sum_reg[j] - SW'(row_eff.cur_bw[j]);
            tot_wide[j] = TW'(bw_val[j]) + TW'(others[j]);
            tot_sat[j]  = (tot_wide[j] > TW'(TOT_MAX)) ? TOT_MAX : tot_wide[j][TOT_W-1:0];
            row_new.cur_bw[j]  = pair_upd[j/2] ? bw_val[j] : row_base.cur_bw[j];
            row_new.pend_bw[j] = bw_en_reg ? bw_ch[j].pend[BW_W-1:0] : row_base.pend_bw[j];
            sum_next[j] = sum_reg[j] - SW'(row_eff.cur_bw[j]) + SW'(row_new.cur_bw[j]);
        end

        // clock vote
        clk_req = release_req ? '0 : req_reg.clock_request_hz;
        clk_ch  = choose_f(clk_req, row_base.pend_clk, row_base.cur_clk);
        clk_val = clk_ch.val;
        clk_upd = release_req || clk_ch.upd;
        if ((clk_val != '0) && (clk_val < min_clk_reg))
        begin
            clk_val = min_clk_reg;
            clk_upd = 1'b1;
        end
        clk_upd          = clk_upd && clk_en_reg;
        row_new.cur_clk  = clk_upd ? clk_val : row_base.cur_clk;
        row_new.pend_clk = clk_en_reg ? clk_ch.pend : row_base.pend_clk;

        // result fields, zero where no vote is issued
        rsp_next                     = '0;
        rsp_next.read_vote_valid     = pair_upd[0];
        rsp_next.read_average_total  = pair_upd[0] ? tot_sat[BW_RD_AVG] : '0;
        rsp_next.read_peak_total     = pair_upd[0] ? tot_sat[BW_RD_PK] : '0;
        rsp_next.write_vote_valid    = pair_upd[1];
        rsp_next.write_average_total = pair_upd[1] ? tot_sat[BW_WR_AVG] : '0;
        rsp_next.write_peak_total    = pair_upd[1] ? tot_sat[BW_WR_PK] : '0;
        rsp_next.bandwidth_commit    = pair_upd[0] || pair_upd[1];
        rsp_next.clock_vote_valid    = clk_upd;
        if (!in_range)
        begin
            rsp_next = '0;
        end
    end

    // state memory: registered read at accept, write back in the calc cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_rd_reg <= row_mem[cmd_addr];
        end
        if ((state_reg == ST_CALC) && in_range)
        begin
            row_mem[addr_reg] <= row_new;
        end
    end

    // row valid bits and running sums of current votes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            sum_reg       <= '0;
        end
        else if ((state_reg == ST_CALC) && in_range)
        begin
            row_valid_reg[addr_reg] <= 1'b1;
            sum_reg                 <= sum_next;
        end
    end

    // result registers; khz from the reciprocal multiply in the last cycle
    logic [PRODW-1:0] khz_prod;

    assign khz_prod = PRODW'(clk_val_reg) * PRODW'(KHZ_RECIP);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            rsp_reg      <= rsp_next;
            clk_vote_reg <= rsp_next.clock_vote_valid;
            clk_val_reg  <= clk_val;
        end
        else if (state_reg == ST_DIV)
        begin
            rsp_reg.clock_vote_khz <= clk_vote_reg ?
                khz_prod[KHZ_SHIFT +: KHZ_W] : '0;
        end
    end

    // one-cycle result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_DIV);
        end
    end

endmodule

[test/qos_vote_deferred_decrease_tb.sv]
// qos_vote_deferred_decrease_tb: self-checking testbench for the bandwidth and clock voter.
// Depends on qvdd_pkg and the qos_vote_deferred_decrease top level; keeps its own copy of
// the vote state, predicts each result and compares it field by field.
module qos_vote_deferred_decrease_tb;

    import qvdd_pkg::*;

    localparam int NUM_PIPES      = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 55;

    localparam logic [BW_W-1:0]   BW_MAX    = {BW_W{1'b1}};
    localparam logic [CLK_W-1:0]  CLK_MAX   = {CLK_W{1'b1}};
    localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    vote_req_t         cmd;
    logic              done;
    vote_rsp_t         result;
    logic              cfg_write;
    logic [CFG_AW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    // configuration copy
    logic [BW_W-1:0]  floor_bw [BW_SLOTS];
    logic [CLK_W-1:0] floor_clk;
    logic             bw_en;
    logic             clk_en;

    // vote state copy
    logic [BW_W-1:0]  cur_bw   [NUM_PIPES][BW_SLOTS];
    logic [BW_W-1:0]  pend_bw  [NUM_PIPES][BW_SLOTS];
    logic [CLK_W-1:0] cur_clk  [NUM_PIPES];
    logic [CLK_W-1:0] pend_clk [NUM_PIPES];

    vote_rsp_t expected_votes[$];
    int        errors      = 0;
    int        idle_cycles = 0;
    bit        no_gaps     = 1'b0;

    qos_vote_deferred_decrease #(
        .NUM_PIPES (NUM_PIPES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mismatch report
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    // raise applies now, a decrease waits one commit; returns 1 when a new vote is due
    function automatic bit defer_decrease(inout logic [CLK_W-1:0] val,
                                          inout logic [CLK_W-1:0] pend,
                                          input logic [CLK_W-1:0] cur);
        logic [CLK_W-1:0] lower;
        lower = val;
        if (val == cur)
        begin
            pend = '0;
            return 1'b0;
        end
        if (val > cur)
        begin
            pend = '0;
            return 1'b1;
        end
        if (pend != '0)
        begin
            if (val >= pend)
            begin
                pend = '0;
            end
            else
            begin
                val  = pend;
                pend = lower;
            end
            return 1'b1;
        end
        pend = val;
        return 1'b0;
    endfunction

    // one direction (read or write): floors, totals over all pipes, state update
    task automatic vote_direction(input int p, input int base,
                                  input logic [BW_W-1:0] req_avg,
                                  input logic [BW_W-1:0] req_pk,
                                  input bit force_vote,
                                  output logic valid,
                                  output logic [TOT_W-1:0] avg_total,
                                  output logic [TOT_W-1:0] pk_total);
        logic [CLK_W-1:0] a;
        logic [CLK_W-1:0] k;
        logic [CLK_W-1:0] pa;
        logic [CLK_W-1:0] pk;
        logic [CLK_W-1:0] sum_a;
        logic [CLK_W-1:0] sum_k;
        bit               upd;
        a   = CLK_W'(req_avg);
        k   = CLK_W'(req_pk);
        pa  = CLK_W'(pend_bw[p][base]);
        pk  = CLK_W'(pend_bw[p][base+1]);
        upd = force_vote;
        upd |= defer_decrease(a, pa, CLK_W'(cur_bw[p][base]));
        upd |= defer_decrease(k, pk, CLK_W'(cur_bw[p][base+1]));
        pend_bw[p][base]   = pa[BW_W-1:0];
        pend_bw[p][base+1] = pk[BW_W-1:0];
        if (a != '0 || k != '0)
        begin
            if (a < CLK_W'(floor_bw[base]))
            begin
                a   = CLK_W'(floor_bw[base]);
                upd = 1'b1;
            end
            if (k < CLK_W'(floor_bw[base+1]))
            begin
                k   = CLK_W'(floor_bw[base+1]);
                upd = 1'b1;
            end
        end
        valid     = 1'b0;
        avg_total = '0;
        pk_total  = '0;
        if (upd)
        begin
            sum_a = a;
            sum_k = k;
            for (int i = 0; i < NUM_PIPES; i++)
            begin
                if (i != p)
                begin
                    sum_a += CLK_W'(cur_bw[i][base]);
                    sum_k += CLK_W'(cur_bw[i][base+1]);
                end
            end
            valid     = 1'b1;
            avg_total = (sum_a > CLK_W'(TOT_MAX)) ? TOT_MAX : sum_a[TOT_W-1:0];
            pk_total  = (sum_k > CLK_W'(TOT_MAX)) ? TOT_MAX : sum_k[TOT_W-1:0];
            cur_bw[p][base]   = a[BW_W-1:0];
            cur_bw[p][base+1] = k[BW_W-1:0];
        end
    endtask

    // expected result of one accepted transaction; advances the state copy
    task automatic predict_vote(input vote_req_t r, output vote_rsp_t e);
        logic [BW_W-1:0]  ra;
        logic [BW_W-1:0]  rp;
        logic [BW_W-1:0]  wa;
        logic [BW_W-1:0]  wp;
        logic [CLK_W-1:0] c;
        logic [CLK_W-1:0] pc;
        logic [CLK_W-1:0] khz;
        logic             rv;
        logic             wv;
        logic [TOT_W-1:0] t0;
        logic [TOT_W-1:0] t1;
        logic [TOT_W-1:0] t2;
        logic [TOT_W-1:0] t3;
        bit               rel;
        bit               upd;
        int               p;
        e   = '0;
        rel = (r.req_type == REQ_RELEASE);
        p   = int'(r.pipe_index);
        ra  = r.read_average_request;
        rp  = r.read_peak_request;
        wa  = r.write_average_request;
        wp  = r.write_peak_request;
        c   = r.clock_request_hz;
        // release clears the row even with voting disabled
        if (rel)
        begin
            ra = '0;
            rp = '0;
            wa = '0;
            wp = '0;
            c  = '0;
            for (int s = 0; s < BW_SLOTS; s++)
            begin
                cur_bw[p][s]  = '0;
                pend_bw[p][s] = '0;
            end
            cur_clk[p]  = '0;
            pend_clk[p] = '0;
        end
        if (bw_en)
        begin
            vote_direction(p, BW_RD_AVG, ra, rp, rel, rv, t0, t1);
            vote_direction(p, BW_WR_AVG, wa, wp, rel, wv, t2, t3);
            e.read_vote_valid     = rv;
            e.read_average_total  = t0;
            e.read_peak_total     = t1;
            e.write_vote_valid    = wv;
            e.write_average_total = t2;
            e.write_peak_total    = t3;
            e.bandwidth_commit    = rv | wv;
        end
        if (clk_en)
        begin
            pc  = pend_clk[p];
            upd = rel;
            upd |= defer_decrease(c, pc, cur_clk[p]);
            pend_clk[p] = pc;
            if (c != '0 && c < floor_clk)
            begin
                c   = floor_clk;
                upd = 1'b1;
            end
            if (upd)
            begin
                khz                = c / 32'd1000;
                e.clock_vote_valid = 1'b1;
                e.clock_vote_khz   = khz[KHZ_W-1:0];
                cur_clk[p]         = c;
            end
        end
    endtask

    // send one transaction after a random gap; predict on acceptance
    task automatic send_vote(input vote_req_t r);
        int        gap;
        vote_rsp_t e;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        cmd   = r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_vote(r, e);
        expected_votes.push_back(e);
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_votes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_MIN_RD_AVG: floor_bw[BW_RD_AVG] = data[BW_W-1:0];
            REG_MIN_RD_PK:  floor_bw[BW_RD_PK]  = data[BW_W-1:0];
            REG_MIN_WR_AVG: floor_bw[BW_WR_AVG] = data[BW_W-1:0];
            REG_MIN_WR_PK:  floor_bw[BW_WR_PK]  = data[BW_W-1:0];
            REG_MIN_CLK:    floor_clk           = data;
            REG_BW_EN:      bw_en               = data[0];
            REG_CLK_EN:     clk_en              = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [BW_W-1:0] f_ra, input logic [BW_W-1:0] f_rp,
                              input logic [BW_W-1:0] f_wa, input logic [BW_W-1:0] f_wp,
                              input logic [CLK_W-1:0] f_clk, input logic bwe,
                              input logic ce);
        write_reg(REG_MIN_RD_AVG, CFG_DW'(f_ra));
        write_reg(REG_MIN_RD_PK,  CFG_DW'(f_rp));
        write_reg(REG_MIN_WR_AVG, CFG_DW'(f_wa));
        write_reg(REG_MIN_WR_PK,  CFG_DW'(f_wp));
        write_reg(REG_MIN_CLK,    f_clk);
        write_reg(REG_BW_EN,      CFG_DW'(bwe));
        write_reg(REG_CLK_EN,     CFG_DW'(ce));
    endtask

    function automatic vote_req_t make_vote(input logic rt, input int p,
                                            input logic [BW_W-1:0] ra,
                                            input logic [BW_W-1:0] rp,
                                            input logic [BW_W-1:0] wa,
                                            input logic [BW_W-1:0] wp,
                                            input logic [CLK_W-1:0] c);
        vote_req_t r;
        r.req_type              = rt;
        r.pipe_index            = p[1:0];
        r.read_average_request  = ra;
        r.read_peak_request     = rp;
        r.write_average_request = wa;
        r.write_peak_request    = wp;
        r.clock_request_hz      = c;
        return r;
    endfunction

    // bandwidth request biased toward the current vote so decreases and repeats are common
    function automatic logic [BW_W-1:0] pick_bw(input logic [BW_W-1:0] cur);
        logic [BW_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = BW_MAX;
            2:       v = BW_W'($urandom_range(0, 20'hFFFFF));
            3:       v = cur;
            4:       v = cur >> 1;
            5:       v = (cur > 50) ? BW_W'(32'(cur) - $urandom_range(1, 50)) : '0;
            default: v = BW_W'($urandom_range(0, 8) * 1000);
        endcase
        return v;
    endfunction

    function automatic logic [CLK_W-1:0] pick_clk(input logic [CLK_W-1:0] cur);
        logic [CLK_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = CLK_MAX;
            2:       v = $urandom();
            3:       v = cur;
            4:       v = cur >> 1;
            5:       v = (cur > 5000) ? cur - $urandom_range(1, 5000) : '0;
            default: v = $urandom_range(0, 8) * 25000000 + $urandom_range(0, 999);
        endcase
        return v;
    endfunction

    function automatic logic [BW_W-1:0] pick_floor();
        logic [BW_W-1:0] v;
        if ($urandom_range(0, 5) == 0)
        begin
            v = BW_W'($urandom_range(0, 20'hFFFFF));
        end
        else
        begin
            v = BW_W'($urandom_range(0, 6) * 500);
        end
        return v;
    endfunction

    function automatic vote_req_t random_vote(input int p);
        logic rt;
        rt = ($urandom_range(0, 11) == 0) ? REQ_RELEASE : REQ_COMMIT;
        return make_vote(rt, p,
                         pick_bw(cur_bw[p][BW_RD_AVG]), pick_bw(cur_bw[p][BW_RD_PK]),
                         pick_bw(cur_bw[p][BW_WR_AVG]), pick_bw(cur_bw[p][BW_WR_PK]),
                         pick_clk(cur_clk[p]));
    endfunction

    // reset values: both paths off, results all zero, release still clears the row
    task automatic test_votes_disabled();
        send_vote(make_vote(REQ_COMMIT, 0, BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX));
        send_vote(make_vote(REQ_COMMIT, 2, 1234, 5678, 910, 1112, 50000000));
        send_vote(make_vote(REQ_RELEASE, 1, BW_MAX, 0, BW_MAX, 0, CLK_MAX));
        wait_idle();
    endtask

    // raises, parked decreases, floors and totals across all pipes
    task automatic test_deferred_decrease();
        set_config(500, 800, 300, 0, 19200000, 1'b1, 1'b1);
        send_vote(make_vote(REQ_COMMIT, 0, 1000, 2000, 0, 0, 100000000));
        send_vote(make_vote(REQ_COMMIT, 0, 1000, 2000, 0, 0, 100000000));
        send_vote(make_vote(REQ_COMMIT, 0, 900, 1900, 700, 100, 90000000));
        send_vote(make_vote(REQ_COMMIT, 0, 700, 1950, 600, 50, 80000000));
        send_vote(make_vote(REQ_COMMIT, 0, 700, 1950, 600, 50, 80000000));
        send_vote(make_vote(REQ_COMMIT, 1, BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX));
        send_vote(make_vote(REQ_COMMIT, 2, BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX));
        send_vote(make_vote(REQ_COMMIT, 3, BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX));
        send_vote(make_vote(REQ_COMMIT, 0, BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX));
        send_vote(make_vote(REQ_COMMIT, 0, 0, 0, 0, 0, 0));
        send_vote(make_vote(REQ_COMMIT, 0, 0, 0, 0, 0, 0));
        send_vote(make_vote(REQ_COMMIT, 2, 10, 10, 10, 10, 1000));
        send_vote(make_vote(REQ_RELEASE, 1, 0, 0, 0, 0, 0));
        send_vote(make_vote(REQ_RELEASE, 3, BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX));
        wait_idle();
    endtask

    // one path enabled at a time, release while the other is off
    task automatic test_single_path();
        write_reg(REG_SPARE, $urandom());
        set_config(0, 0, 0, 0, 0, 1'b1, 1'b0);
        send_vote(make_vote(REQ_COMMIT, 2, 40, 0, 0, 70, 60000000));
        send_vote(make_vote(REQ_RELEASE, 0, 5, 5, 5, 5, 5));
        wait_idle();
        set_config(0, 0, 0, 0, 0, 1'b0, 1'b1);
        send_vote(make_vote(REQ_COMMIT, 3, 40, 40, 40, 40, 999));
        send_vote(make_vote(REQ_RELEASE, 2, 0, 0, 0, 0, CLK_MAX));
        wait_idle();
    endtask

    // random phases: short runs on one pipe so parked decreases get applied
    task automatic test_random_phases();
        int n;
        int p;
        int run;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_config(0, 0, 0, 0, 0, 1'b1, 1'b1);
                1: set_config(BW_MAX, BW_MAX, BW_MAX, BW_MAX, CLK_MAX, 1'b1, 1'b1);
                2: set_config(pick_floor(), pick_floor(), pick_floor(), pick_floor(),
                              $urandom(), 1'b1, 1'b0);
                3: set_config(pick_floor(), pick_floor(), pick_floor(), pick_floor(),
                              $urandom_range(0, 50000000), 1'b0, 1'b1);
                default: set_config(pick_floor(), pick_floor(), pick_floor(), pick_floor(),
                                    $urandom_range(0, 4) * 10000000,
                                    $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            endcase
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                p       = $urandom_range(0, NUM_PIPES - 1);
                run     = $urandom_range(1, 5);
                no_gaps = ($urandom_range(0, 3) == 0);
                repeat (run)
                begin
                    send_vote(random_vote(p));
                    n++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        vote_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_votes.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                want = expected_votes.pop_front();
                check_field("read_vote_valid", 32'(result.read_vote_valid),
                            32'(want.read_vote_valid));
                check_field("read_average_total", 32'(result.read_average_total),
                            32'(want.read_average_total));
                check_field("read_peak_total", 32'(result.read_peak_total),
                            32'(want.read_peak_total));
                check_field("write_vote_valid", 32'(result.write_vote_valid),
                            32'(want.write_vote_valid));
                check_field("write_average_total", 32'(result.write_average_total),
                            32'(want.write_average_total));
                check_field("write_peak_total", 32'(result.write_peak_total),
                            32'(want.write_peak_total));
                check_field("bandwidth_commit", 32'(result.bandwidth_commit),
                            32'(want.bandwidth_commit));
                check_field("clock_vote_valid", 32'(result.clock_vote_valid),
                            32'(want.clock_vote_valid));
                check_field("clock_vote_khz", 32'(result.clock_vote_khz),
                            32'(want.clock_vote_khz));
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("qos_vote_deferred_decrease_tb: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        floor_clk = '0;
        bw_en     = 1'b0;
        clk_en    = 1'b0;
        for (int p = 0; p < NUM_PIPES; p++)
        begin
            for (int s = 0; s < BW_SLOTS; s++)
            begin
                cur_bw[p][s]  = '0;
                pend_bw[p][s] = '0;
            end
            cur_clk[p]  = '0;
            pend_clk[p] = '0;
        end
        for (int s = 0; s < BW_SLOTS; s++)
        begin
            floor_bw[s] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_votes_disabled();
        test_deferred_decrease();
        test_single_path();
        test_random_phases();
        wait_idle();

        if (errors == 0)
        begin
            $display("qos_vote_deferred_decrease_tb: clean");
        end
        else
        begin
            $display("qos_vote_deferred_decrease_tb: errors");
        end
        $finish;
    end

endmodule
